// File: hw/rtl/ppnt_pkg.sv
`timescale 1ns / 1ps

package ppnt_pkg;

	// APB address width: eight 64-bit registers at a stride of 8 bytes.
	localparam int unsigned ADDR_W = 6;

	// Register indexes, taken from paddr[5:3].
	localparam logic [2:0] REG_CELL_XX       = 3'd0;
	localparam logic [2:0] REG_CELL_XY       = 3'd1;
	localparam logic [2:0] REG_CELL_XZ       = 3'd2;
	localparam logic [2:0] REG_CELL_YY       = 3'd3;
	localparam logic [2:0] REG_CELL_YZ       = 3'd4;
	localparam logic [2:0] REG_CELL_ZZ       = 3'd5;
	localparam logic [2:0] REG_PERIODIC_MASK = 3'd6;
	localparam logic [2:0] REG_CUTOFF_SQUARE = 3'd7;

	// Image shift codes, two bits signed.
	localparam logic [1:0] SHIFT_NONE = 2'b00;
	localparam logic [1:0] SHIFT_POS  = 2'b01;
	localparam logic [1:0] SHIFT_BAD  = 2'b10;
	localparam logic [1:0] SHIFT_NEG  = 2'b11;

	// Configuration as seen by the datapath; signed fields are reinterpreted at use.
	typedef struct packed {
		logic [30:0] xx;
		logic [31:0] xy;
		logic [31:0] xz;
		logic [30:0] yy;
		logic [31:0] yz;
		logic [30:0] zz;
		logic [2:0]  mask;
		logic [62:0] cutoff;
	} cfg_t;

	// Hand-off from the fraction pipeline to the distance pipeline.
	typedef struct packed {
		logic        valid;
		logic        en;
		logic [1:0]  sx;
		logic [1:0]  sy;
		logic [1:0]  sz;
		logic [32:0] dx;
		logic [32:0] dy;
		logic [32:0] dz;
	} frac_t;

endpackage

// File: hw/rtl/ppnt_cfg.sv
`timescale 1ns / 1ps

module ppnt_cfg #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ppnt_pkg::ADDR_W-1:0] paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready,
	output ppnt_pkg::cfg_t              cfg
);

	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[5:3];

	// Register file; the diagonal resets to one cell length of 1.0.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.xx     <= 31'(1) << FRACTION_BITS;
			cfg.xy     <= '0;
			cfg.xz     <= '0;
			cfg.yy     <= 31'(1) << FRACTION_BITS;
			cfg.yz     <= '0;
			cfg.zz     <= 31'(1) << FRACTION_BITS;
			cfg.mask   <= '0;
			cfg.cutoff <= '0;
		end else if (wr_en) begin
			case (idx)
				ppnt_pkg::REG_CELL_XX:       cfg.xx     <= pwdata[30:0];
				ppnt_pkg::REG_CELL_XY:       cfg.xy     <= pwdata[31:0];
				ppnt_pkg::REG_CELL_XZ:       cfg.xz     <= pwdata[31:0];
				ppnt_pkg::REG_CELL_YY:       cfg.yy     <= pwdata[30:0];
				ppnt_pkg::REG_CELL_YZ:       cfg.yz     <= pwdata[31:0];
				ppnt_pkg::REG_CELL_ZZ:       cfg.zz     <= pwdata[30:0];
				ppnt_pkg::REG_PERIODIC_MASK: cfg.mask   <= pwdata[2:0];
				ppnt_pkg::REG_CUTOFF_SQUARE: cfg.cutoff <= pwdata[62:0];
				default: ;
			endcase
		end
	end

	// Read back; signed cell terms are sign extended.
	always_comb begin
		case (idx)
			ppnt_pkg::REG_CELL_XX:       prdata = {33'b0, cfg.xx};
			ppnt_pkg::REG_CELL_XY:       prdata = 64'($signed(cfg.xy));
			ppnt_pkg::REG_CELL_XZ:       prdata = 64'($signed(cfg.xz));
			ppnt_pkg::REG_CELL_YY:       prdata = {33'b0, cfg.yy};
			ppnt_pkg::REG_CELL_YZ:       prdata = 64'($signed(cfg.yz));
			ppnt_pkg::REG_CELL_ZZ:       prdata = {33'b0, cfg.zz};
			ppnt_pkg::REG_PERIODIC_MASK: prdata = {61'b0, cfg.mask};
			ppnt_pkg::REG_CUTOFF_SQUARE: prdata = {1'b0, cfg.cutoff};
			default:                     prdata = '0;
		endcase
	end

endmodule

// File: hw/rtl/ppnt_frac.sv
`timescale 1ns / 1ps

module ppnt_frac (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic signed [31:0]    first_x,
	input  logic signed [31:0]    first_y,
	input  logic signed [31:0]    first_z,
	input  logic signed [31:0]    second_x,
	input  logic signed [31:0]    second_y,
	input  logic signed [31:0]    second_z,
	input  logic                  pair_enabled,
	input  ppnt_pkg::cfg_t        cfg,
	output ppnt_pkg::frac_t       frac
);

	// Shift for a fraction num/den: wrap when twice |num| exceeds den.
	function automatic logic [1:0] half_code(input logic signed [101:0] num,
		input logic [92:0] den);
		logic [101:0] m;
		logic [1:0]   code;
		m = num[101] ? 102'(-num) : 102'(num);
		if ({m, 1'b0} > {10'b0, den})
			code = num[101] ? ppnt_pkg::SHIFT_POS : ppnt_pkg::SHIFT_NEG;
		else
			code = ppnt_pkg::SHIFT_NONE;
		return code;
	endfunction

	logic signed [31:0] xx_w, yy_w, zz_w, xy_w, xz_w, yz_w;

	assign xx_w = $signed({1'b0, cfg.xx});
	assign yy_w = $signed({1'b0, cfg.yy});
	assign zz_w = $signed({1'b0, cfg.zz});
	assign xy_w = $signed(cfg.xy);
	assign xz_w = $signed(cfg.xz);
	assign yz_w = $signed(cfg.yz);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7;
	logic signed [32:0] dx_s1, dy_s1, dz_s1, dx_s2, dy_s2, dz_s2, dx_s3, dy_s3, dz_s3;
	logic signed [32:0] dx_s4, dy_s4, dz_s4, dx_s5, dy_s5, dz_s5, dx_s6, dy_s6, dz_s6;
	logic signed [32:0] dx_s7, dy_s7, dz_s7;
	logic signed [64:0] dyzz_s2, dzyz_s2, dxyy_s2, dzyy_s2;
	logic [61:0]        deny_s2, deny_s3;
	logic [1:0]         sz_s2, sz_s3, sz_s4, sz_s5, sz_s6, sz_s7;
	logic [1:0]         sy_s4, sy_s5, sy_s6, sy_s7, sx_s7;
	logic signed [65:0] ny_s3;
	logic signed [64:0] axl_s3, axh_s3, bzl_s3, bzh_s3;
	logic [62:0]        dxl_s3;
	logic [60:0]        dxh_s3;
	logic signed [97:0] a_s4, b_s4;
	logic [92:0]        denx_s4, denx_s5, denx_s6;
	logic signed [64:0] t0_s4, t1_s4;
	logic signed [33:0] t2_s4;
	logic signed [98:0] ab_s5;
	logic signed [99:0] t_s5;
	logic signed [100:0] nx_s6;

	// Valid and enable travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Stage 1: difference vector.
	always_ff @(posedge clk) begin
		en_s1 <= pair_enabled;
		dx_s1 <= 33'(first_x) - 33'(second_x);
		dy_s1 <= 33'(first_y) - 33'(second_y);
		dz_s1 <= 33'(first_z) - 33'(second_z);
	end

	// Stage 2: first products and the z fraction test.
	always_ff @(posedge clk) begin
		en_s2   <= en_s1;
		dx_s2   <= dx_s1;
		dy_s2   <= dy_s1;
		dz_s2   <= dz_s1;
		dyzz_s2 <= 65'(dy_s1) * 65'(zz_w);
		dzyz_s2 <= 65'(dz_s1) * 65'(yz_w);
		dxyy_s2 <= 65'(dx_s1) * 65'(yy_w);
		dzyy_s2 <= 65'(dz_s1) * 65'(yy_w);
		deny_s2 <= 62'(cfg.yy) * 62'(cfg.zz);
		sz_s2   <= cfg.mask[2] ? half_code(102'(dz_s1), 93'(cfg.zz)) : ppnt_pkg::SHIFT_NONE;
	end

	// Stage 3: y numerator and 32-bit partial products of the triple terms.
	always_ff @(posedge clk) begin
		en_s3   <= en_s2;
		dx_s3   <= dx_s2;
		dy_s3   <= dy_s2;
		dz_s3   <= dz_s2;
		sz_s3   <= sz_s2;
		deny_s3 <= deny_s2;
		ny_s3   <= 66'(dyzz_s2) - 66'(dzyz_s2);
		axl_s3  <= 65'($signed({1'b0, dxyy_s2[31:0]})) * 65'(zz_w);
		axh_s3  <= 65'($signed(dxyy_s2[64:32])) * 65'(zz_w);
		bzl_s3  <= 65'($signed({1'b0, dzyy_s2[31:0]})) * 65'(xz_w);
		bzh_s3  <= 65'($signed(dzyy_s2[64:32])) * 65'(xz_w);
		dxl_s3  <= 63'(deny_s2[31:0]) * 63'(cfg.xx);
		dxh_s3  <= 61'(deny_s2[61:32]) * 61'(cfg.xx);
	end

	// Stage 4: combine partials, y fraction test, partials of xy times ny.
	always_ff @(posedge clk) begin
		en_s4   <= en_s3;
		dx_s4   <= dx_s3;
		dy_s4   <= dy_s3;
		dz_s4   <= dz_s3;
		sz_s4   <= sz_s3;
		a_s4    <= 98'($signed({axh_s3, 32'b0})) + 98'(axl_s3);
		b_s4    <= 98'($signed({bzh_s3, 32'b0})) + 98'(bzl_s3);
		denx_s4 <= {dxh_s3, 32'b0} + 93'(dxl_s3);
		sy_s4   <= cfg.mask[1] ? half_code(102'(ny_s3), 93'(deny_s3)) : ppnt_pkg::SHIFT_NONE;
		t0_s4   <= 65'(xy_w) * 65'($signed({1'b0, ny_s3[31:0]}));
		t1_s4   <= 65'(xy_w) * 65'($signed({1'b0, ny_s3[63:32]}));
		t2_s4   <= 34'(xy_w) * 34'($signed(ny_s3[65:64]));
	end

	// Stage 5: sums of the x numerator terms.
	always_ff @(posedge clk) begin
		en_s5   <= en_s4;
		dx_s5   <= dx_s4;
		dy_s5   <= dy_s4;
		dz_s5   <= dz_s4;
		sz_s5   <= sz_s4;
		sy_s5   <= sy_s4;
		denx_s5 <= denx_s4;
		ab_s5   <= 99'(a_s4) - 99'(b_s4);
		t_s5    <= 100'(t0_s4) + 100'($signed({t1_s4, 32'b0}))
			+ 100'($signed({t2_s4, 64'b0}));
	end

	// Stage 6: x numerator.
	always_ff @(posedge clk) begin
		en_s6   <= en_s5;
		dx_s6   <= dx_s5;
		dy_s6   <= dy_s5;
		dz_s6   <= dz_s5;
		sz_s6   <= sz_s5;
		sy_s6   <= sy_s5;
		denx_s6 <= denx_s5;
		nx_s6   <= 101'(ab_s5) - 101'(t_s5);
	end

	// Stage 7: x fraction test.
	always_ff @(posedge clk) begin
		en_s7 <= en_s6;
		dx_s7 <= dx_s6;
		dy_s7 <= dy_s6;
		dz_s7 <= dz_s6;
		sz_s7 <= sz_s6;
		sy_s7 <= sy_s6;
		sx_s7 <= cfg.mask[0] ? half_code(102'(nx_s6), denx_s6) : ppnt_pkg::SHIFT_NONE;
	end

	assign frac.valid = v_s7;
	assign frac.en    = en_s7;
	assign frac.sx    = sx_s7;
	assign frac.sy    = sy_s7;
	assign frac.sz    = sz_s7;
	assign frac.dx    = dx_s7;
	assign frac.dy    = dy_s7;
	assign frac.dz    = dz_s7;

endmodule

// File: hw/rtl/ppnt_dist.sv
`timescale 1ns / 1ps

module ppnt_dist (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ppnt_pkg::frac_t        frac,
	input  ppnt_pkg::cfg_t         cfg,
	output logic                   done,
	output logic                   is_neighbor,
	output logic signed [1:0]      shift_x,
	output logic signed [1:0]      shift_y,
	output logic signed [1:0]      shift_z
);

	// Cell column term times a shift of -1, 0 or +1.
	function automatic logic signed [33:0] sel(input logic [1:0] code,
		input logic signed [32:0] v);
		logic signed [33:0] r;
		case (code)
			ppnt_pkg::SHIFT_POS: r = 34'(v);
			ppnt_pkg::SHIFT_NEG: r = -34'(v);
			default:             r = '0;
		endcase
		return r;
	endfunction

	logic signed [32:0] xx_w, yy_w, zz_w, xy_w, xz_w, yz_w;

	assign xx_w = $signed({2'b0, cfg.xx});
	assign yy_w = $signed({2'b0, cfg.yy});
	assign zz_w = $signed({2'b0, cfg.zz});
	assign xy_w = 33'($signed(cfg.xy));
	assign xz_w = 33'($signed(cfg.xz));
	assign yz_w = 33'($signed(cfg.yz));

	logic               v_s8, v_s9, v_s10;
	logic               en_s8, en_s9, en_s10;
	logic [1:0]         sx_s8, sy_s8, sz_s8, sx_s9, sy_s9, sz_s9, sx_s10, sy_s10, sz_s10;
	logic signed [34:0] wx_s8, wy_s8, wz_s8;
	logic [34:0]        mx_w, my_w, mz_w;
	logic [31:0]        ax_s9, ay_s9, az_s9;
	logic               big_s9, big_s10;
	logic [63:0]        qx_s10, qy_s10, qz_s10;
	logic [65:0]        sum_w;
	logic               hit_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			v_s8  <= frac.valid;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	// Stage 8: wrapped vector w = d + M s.
	always_ff @(posedge clk) begin
		en_s8 <= frac.en;
		sx_s8 <= frac.sx;
		sy_s8 <= frac.sy;
		sz_s8 <= frac.sz;
		wx_s8 <= 35'($signed(frac.dx)) + 35'(sel(frac.sx, xx_w)) + 35'(sel(frac.sy, xy_w))
			+ 35'(sel(frac.sz, xz_w));
		wy_s8 <= 35'($signed(frac.dy)) + 35'(sel(frac.sy, yy_w)) + 35'(sel(frac.sz, yz_w));
		wz_s8 <= 35'($signed(frac.dz)) + 35'(sel(frac.sz, zz_w));
	end

	// Stage 9: magnitudes; any of 2^32 or more rules the pair out.
	assign mx_w = wx_s8[34] ? 35'(-wx_s8) : 35'(wx_s8);
	assign my_w = wy_s8[34] ? 35'(-wy_s8) : 35'(wy_s8);
	assign mz_w = wz_s8[34] ? 35'(-wz_s8) : 35'(wz_s8);

	always_ff @(posedge clk) begin
		en_s9  <= en_s8;
		sx_s9  <= sx_s8;
		sy_s9  <= sy_s8;
		sz_s9  <= sz_s8;
		ax_s9  <= mx_w[31:0];
		ay_s9  <= my_w[31:0];
		az_s9  <= mz_w[31:0];
		big_s9 <= (|mx_w[34:32]) | (|my_w[34:32]) | (|mz_w[34:32]);
	end

	// Stage 10: squares.
	always_ff @(posedge clk) begin
		en_s10  <= en_s9;
		sx_s10  <= sx_s9;
		sy_s10  <= sy_s9;
		sz_s10  <= sz_s9;
		big_s10 <= big_s9;
		qx_s10  <= 64'(ax_s9) * 64'(ax_s9);
		qy_s10  <= 64'(ay_s9) * 64'(ay_s9);
		qz_s10  <= 64'(az_s9) * 64'(az_s9);
	end

	// Stage 11: squared norm against the cutoff; outputs read zero between transactions.
	assign sum_w = 66'(qx_s10) + 66'(qy_s10) + 66'(qz_s10);
	assign hit_w = !big_s10 && (sum_w != '0) && (sum_w < 66'(cfg.cutoff));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done        <= 1'b0;
			is_neighbor <= 1'b0;
			shift_x     <= '0;
			shift_y     <= '0;
			shift_z     <= '0;
		end else begin
			done        <= v_s10;
			is_neighbor <= v_s10 & en_s10 & hit_w;
			shift_x     <= (v_s10 & en_s10) ? sx_s10 : ppnt_pkg::SHIFT_NONE;
			shift_y     <= (v_s10 & en_s10) ? sy_s10 : ppnt_pkg::SHIFT_NONE;
			shift_z     <= (v_s10 & en_s10) ? sz_s10 : ppnt_pkg::SHIFT_NONE;
		end
	end

endmodule

// File: hw/rtl/periodic_pair_neighbor_test.sv
`timescale 1ns / 1ps

// Minimum-image cutoff test for one pair of positions in a triclinic cell. The block
// takes one transaction in every clock cycle (busy stays low) and raises done with the
// result of each one; the depth is set by the exact fractional-coordinate products,
// which run as 32-bit partial products through seven stages, followed by four stages
// for the wrapped vector, its magnitudes, its squares and the cutoff compare. Results
// cannot be held off, so they must be taken in the cycle done is high.
// Cell registers are to be written only while no transaction is in flight.
module periodic_pair_neighbor_test #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [31:0]          first_x,
	input  logic signed [31:0]          first_y,
	input  logic signed [31:0]          first_z,
	input  logic signed [31:0]          second_x,
	input  logic signed [31:0]          second_y,
	input  logic signed [31:0]          second_z,
	input  logic                        pair_enabled,
	output logic                        done,
	output logic                        is_neighbor,
	output logic signed [1:0]           shift_x,
	output logic signed [1:0]           shift_y,
	output logic signed [1:0]           shift_z,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ppnt_pkg::ADDR_W-1:0] paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready
);

	ppnt_pkg::cfg_t  cfg;
	ppnt_pkg::frac_t frac;

	// The pipeline never stalls.
	assign busy = 1'b0;

	ppnt_cfg #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ppnt_frac u_frac (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (start & ~busy),
		.first_x      (first_x),
		.first_y      (first_y),
		.first_z      (first_z),
		.second_x     (second_x),
		.second_y     (second_y),
		.second_z     (second_z),
		.pair_enabled (pair_enabled),
		.cfg          (cfg),
		.frac         (frac)
	);

	ppnt_dist u_dist (
		.clk         (clk),
		.arst_n      (arst_n),
		.frac        (frac),
		.cfg         (cfg),
		.done        (done),
		.is_neighbor (is_neighbor),
		.shift_x     (shift_x),
		.shift_y     (shift_y),
		.shift_z     (shift_z)
	);

`ifndef ASSERT_OFF
	// Shift codes stay within -1..1.
	a_shift_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(shift_x != ppnt_pkg::SHIFT_BAD) && (shift_y != ppnt_pkg::SHIFT_BAD)
		&& (shift_z != ppnt_pkg::SHIFT_BAD))
		else $error("illegal shift code");

	// A neighbor flag only appears with a result.
	a_nb_done: assert property (@(posedge clk) disable iff (!arst_n)
		is_neighbor |-> done)
		else $error("is_neighbor without done");

	// A nonzero shift only appears with a result.
	a_shift_done: assert property (@(posedge clk) disable iff (!arst_n)
		((shift_x != ppnt_pkg::SHIFT_NONE) || (shift_y != ppnt_pkg::SHIFT_NONE)
		|| (shift_z != ppnt_pkg::SHIFT_NONE)) |-> done)
		else $error("shift without done");
`endif

endmodule
